/* hdl/polygon_area_perimeter_convexity_unit_macros.svh */
// Assertion macros for the polygon measure unit and its port checker.
// Depends on nothing; included by the checker file only.
`ifndef POLYGON_AREA_PERIMETER_CONVEXITY_UNIT_MACROS_SVH
`define POLYGON_AREA_PERIMETER_CONVEXITY_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PAPCU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define PAPCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/papcu_pkg.sv */
// Shared types, constants and the serial multiply step of the polygon measure unit.
// Depends on nothing; used by the top level and by the port checker.
package papcu_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_VERTICES  = 1024;
   localparam int DEF_FRACTION_BITS = 8;

   // Fixed widths of the datapath
   localparam int COORD_W       = 16;   // vertex coordinate
   localparam int DIFF_W        = 17;   // edge component
   localparam int ACC_W         = 35;   // serial product accumulator
   localparam int RAD_W         = 36;   // square root radicand
   localparam int INT_ROOT_BITS = 18;   // integer bits of an edge root
   localparam int MUL_STEPS     = 17;   // one multiplier bit per cycle

   // Result fields
   localparam int AREA_W  = 42;
   localparam int PERIM_W = 35;
   localparam int TOTAL_W = 11;

   // Channel packing
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 96;
   localparam int PERIM_LSB   = AREA_W;
   localparam int CONVEX_BIT  = PERIM_LSB + PERIM_W;
   localparam int TOTAL_LSB   = CONVEX_BIT + 1;
   localparam int FEW_BIT     = TOTAL_LSB + TOTAL_W;
   localparam int MANY_BIT    = FEW_BIT + 1;
   localparam int RSP_PAD_W   = RSP_DATA_W - MANY_BIT - 1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_APPLY,
      ST_ROOT,
      ST_SUM,
      ST_DISPATCH,
      ST_FINISH
   } state_type;

   // What the current pass through the multiply unit is for
   typedef enum logic [1:0] {
      JOB_VERTEX,
      JOB_CLOSE_EDGE,
      JOB_CLOSE_TURN
   } job_type;

   // One MSB-first step of acc + p*qbit -/+ q*qbit; the sign bit comes first
   // and carries negative weight.
   function automatic logic signed [ACC_W-1:0] horner_step(
      input logic signed [ACC_W-1:0]  acc,
      input logic signed [DIFF_W-1:0] p,
      input logic signed [DIFF_W-1:0] q,
      input logic                     p_bit,
      input logic                     q_bit,
      input logic                     first,
      input logic                     negate_q);
      logic signed [ACC_W-1:0] tp;
      logic signed [ACC_W-1:0] tq;
      logic signed [ACC_W-1:0] sum;
      tp  = p_bit ? ACC_W'(p) : '0;
      tq  = q_bit ? ACC_W'(q) : '0;
      sum = negate_q ? (tp - tq) : (tp + tq);
      return first ? -sum : ((acc <<< 1) + sum);
   endfunction

endpackage

/* hdl/polygon_area_perimeter_convexity_unit.sv */
// Polygon measure unit: shoelace area, perimeter and convexity of a vertex ring.
// Depends on papcu_pkg (types, widths, serial multiply step).
//
// Usage:
//   Vertices enter on the req_ channel, one per transfer, x in req_tdata[15:0]
//   and y in req_tdata[31:16], both signed; req_tlast marks the last vertex.
//   One result leaves on the rsp_ channel for each marked vertex.
//   Each edge runs through a bit-serial multiply unit (one multiplier bit
//   per cycle, three products in parallel) and then a restoring square
//   root that yields one root bit per cycle; req_tready is high only while
//   the unit is idle. A marked vertex that closes a ring of three or more
//   vertices adds the closing edge and the closing turn before the result
//   is registered. Vertices past MAX_VERTICES are dropped.
//   Reset is synchronous and clears the running sums, the count and the
//   output valid. The result sits in an output register: the unit takes the
//   next polygon while a stalled result waits, and only holds in its final
//   cycle of a polygon until that register is free.
module polygon_area_perimeter_convexity_unit #(
   parameter int MAX_VERTICES  = papcu_pkg::DEF_MAX_VERTICES,
   parameter int FRACTION_BITS = papcu_pkg::DEF_FRACTION_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // vertex_x [15:0], vertex_y [31:16]
   input  logic [papcu_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // double_area [41:0], perimeter_fx [76:42], is_convex [77],
   // vertex_total [88:78], too_few [89], too_many [90], zeros [95:91]
   output logic [papcu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready
);

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int SL_W   = 33 + $clog2(MAX_VERTICES);
   localparam int MAG_W  = (SL_W > papcu_pkg::AREA_W) ? SL_W : papcu_pkg::AREA_W;
   localparam int ROOT_W = papcu_pkg::INT_ROOT_BITS + FRACTION_BITS;
   localparam int REM_W  = ROOT_W + 3;
   localparam int STEP_W = $clog2(ROOT_W + 1);
   localparam int CW     = papcu_pkg::COORD_W;
   localparam int DW     = papcu_pkg::DIFF_W;
   localparam int AW     = papcu_pkg::ACC_W;
   localparam int RW     = papcu_pkg::RAD_W;

   // Control state
   papcu_pkg::state_type state_ff, state_in;
   papcu_pkg::job_type   job_ff, job_in;
   logic                 pend_last_ff, pend_last_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 over_ff, over_in;
   logic [1:0]           flags_ff, flags_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 do_edge_ff, do_edge_in;
   logic                 do_turn_ff, do_turn_in;
   logic signed [SL_W-1:0] shoelace_ff, shoelace_in;
   logic [papcu_pkg::PERIM_W-1:0] length_ff, length_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Ring registers
   logic signed [CW-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [CW-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [DW-1:0] fedge_x_ff, fedge_x_in, fedge_y_ff, fedge_y_in;
   logic signed [DW-1:0] pedge_x_ff, pedge_x_in, pedge_y_ff, pedge_y_in;

   // Serial multiply unit: multiplicands, multiplier shift registers, accumulators
   logic signed [DW-1:0] m_ax_ff, m_ax_in, m_bx_ff, m_bx_in;
   logic signed [DW-1:0] m_dx_ff, m_dx_in, m_dy_ff, m_dy_in;
   logic signed [DW-1:0] m_nx_ff, m_nx_in, m_ox_ff, m_ox_in;
   logic [DW-1:0]        q_by_ff, q_by_in, q_ay_ff, q_ay_in;
   logic [DW-1:0]        q_dx_ff, q_dx_in, q_dy_ff, q_dy_in;
   logic [DW-1:0]        q_oy_ff, q_oy_in, q_ny_ff, q_ny_in;
   logic signed [AW-1:0] acc_area_ff, acc_area_in;
   logic signed [AW-1:0] acc_sq_ff, acc_sq_in;
   logic signed [AW-1:0] acc_turn_ff, acc_turn_in;

   // Serial square root
   logic [RW-1:0]        rad_ff, rad_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;

   // Result register
   logic [papcu_pkg::AREA_W-1:0]  area_ff, area_in;
   logic [papcu_pkg::PERIM_W-1:0] perim_ff, perim_in;
   logic                          convex_ff, convex_in;
   logic [papcu_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                          few_ff, few_in;
   logic                          many_ff, many_in;

   // Combinational helpers
   logic signed [CW-1:0] cur_x, cur_y;
   logic signed [DW-1:0] dx_new, dy_new, close_x, close_y;
   logic                 vertex_full;
   logic                 few;
   logic                 mul_first;
   logic                 ld_en, ld_edge, ld_turn;
   logic signed [CW-1:0] ld_ax, ld_ay, ld_bx, ld_by;
   logic signed [DW-1:0] ld_nx, ld_ny, ld_ox, ld_oy;
   logic signed [DW-1:0] ld_dx, ld_dy;
   logic [REM_W-1:0]     rem_sh, trial;
   logic [RW-1:0]        len_sum;
   logic [SL_W-1:0]      mag;
   logic [MAG_W-1:0]     mag_ext, area_max;
   logic                 out_load;

   assign cur_x       = req_tdata[CW-1:0];
   assign cur_y       = req_tdata[2*CW-1:CW];
   assign dx_new      = DW'(cur_x) - DW'(prev_x_ff);
   assign dy_new      = DW'(cur_y) - DW'(prev_y_ff);
   assign close_x     = DW'(first_x_ff) - DW'(prev_x_ff);
   assign close_y     = DW'(first_y_ff) - DW'(prev_y_ff);
   assign vertex_full = (count_ff >= CNT_W'(MAX_VERTICES));
   assign few         = (count_ff < CNT_W'(3));
   assign mul_first   = (step_ff == '0);

   // Root step: bring down two radicand bits and try the next root bit
   assign rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RW-1:RW-2]};
   assign trial   = REM_W'({root_ff, 2'b01});
   assign len_sum = {1'b0, length_ff} + RW'(root_ff);

   // Area magnitude and its clamp to the field maximum
   assign mag      = shoelace_ff[SL_W-1] ? SL_W'(-shoelace_ff) : SL_W'(shoelace_ff);
   assign mag_ext  = MAG_W'(mag);
   assign area_max = MAG_W'({papcu_pkg::AREA_W{1'b1}});

   assign ld_dx = DW'(ld_bx) - DW'(ld_ax);
   assign ld_dy = DW'(ld_by) - DW'(ld_ay);

   // Sequencer: next state, ring update, job loading and datapath steps
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      pend_last_in = pend_last_ff;
      count_in     = count_ff;
      over_in      = over_ff;
      flags_in     = flags_ff;
      step_in      = step_ff;
      do_edge_in   = do_edge_ff;
      do_turn_in   = do_turn_ff;
      shoelace_in  = shoelace_ff;
      length_in    = length_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      fedge_x_in   = fedge_x_ff;
      fedge_y_in   = fedge_y_ff;
      pedge_x_in   = pedge_x_ff;
      pedge_y_in   = pedge_y_ff;
      m_ax_in      = m_ax_ff;
      m_bx_in      = m_bx_ff;
      m_dx_in      = m_dx_ff;
      m_dy_in      = m_dy_ff;
      m_nx_in      = m_nx_ff;
      m_ox_in      = m_ox_ff;
      q_by_in      = q_by_ff;
      q_ay_in      = q_ay_ff;
      q_dx_in      = q_dx_ff;
      q_dy_in      = q_dy_ff;
      q_oy_in      = q_oy_ff;
      q_ny_in      = q_ny_ff;
      acc_area_in  = acc_area_ff;
      acc_sq_in    = acc_sq_ff;
      acc_turn_in  = acc_turn_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      area_in      = area_ff;
      perim_in     = perim_ff;
      convex_in    = convex_ff;
      total_in     = total_ff;
      few_in       = few_ff;
      many_in      = many_ff;
      out_load     = 1'b0;
      ld_en        = 1'b0;
      ld_edge      = 1'b1;
      ld_turn      = 1'b1;
      ld_ax        = prev_x_ff;
      ld_ay        = prev_y_ff;
      ld_bx        = first_x_ff;
      ld_by        = first_y_ff;
      ld_nx        = close_x;
      ld_ny        = close_y;
      ld_ox        = pedge_x_ff;
      ld_oy        = pedge_y_ff;
      req_tready   = (state_ff == papcu_pkg::ST_IDLE);

      unique case (state_ff)
         papcu_pkg::ST_IDLE: begin
            // Take a vertex: drop it when full, store it when first, else start its edge
            if (req_tvalid) begin
               pend_last_in = req_tlast;
               job_in       = papcu_pkg::JOB_VERTEX;
               if (vertex_full) begin
                  over_in  = 1'b1;
                  state_in = req_tlast ? papcu_pkg::ST_DISPATCH : papcu_pkg::ST_IDLE;
               end else if (count_ff == '0) begin
                  first_x_in = cur_x;
                  first_y_in = cur_y;
                  prev_x_in  = cur_x;
                  prev_y_in  = cur_y;
                  count_in   = count_ff + CNT_W'(1);
                  state_in   = req_tlast ? papcu_pkg::ST_DISPATCH : papcu_pkg::ST_IDLE;
               end else begin
                  ld_en   = 1'b1;
                  ld_bx   = cur_x;
                  ld_by   = cur_y;
                  ld_nx   = dx_new;
                  ld_ny   = dy_new;
                  ld_turn = (count_ff != CNT_W'(1));
                  if (count_ff == CNT_W'(1)) begin
                     fedge_x_in = dx_new;
                     fedge_y_in = dy_new;
                  end
                  pedge_x_in = dx_new;
                  pedge_y_in = dy_new;
                  prev_x_in  = cur_x;
                  prev_y_in  = cur_y;
                  count_in   = count_ff + CNT_W'(1);
                  state_in   = papcu_pkg::ST_MUL;
               end
            end
         end
         papcu_pkg::ST_MUL: begin
            // One multiplier bit of all three products, MSB first
            acc_area_in = papcu_pkg::horner_step(acc_area_ff, m_ax_ff, m_bx_ff,
                             q_by_ff[DW-1], q_ay_ff[DW-1], mul_first, 1'b1);
            acc_sq_in   = papcu_pkg::horner_step(acc_sq_ff, m_dx_ff, m_dy_ff,
                             q_dx_ff[DW-1], q_dy_ff[DW-1], mul_first, 1'b0);
            acc_turn_in = papcu_pkg::horner_step(acc_turn_ff, m_nx_ff, m_ox_ff,
                             q_oy_ff[DW-1], q_ny_ff[DW-1], mul_first, 1'b1);
            q_by_in = q_by_ff << 1;
            q_ay_in = q_ay_ff << 1;
            q_dx_in = q_dx_ff << 1;
            q_dy_in = q_dy_ff << 1;
            q_oy_in = q_oy_ff << 1;
            q_ny_in = q_ny_ff << 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(papcu_pkg::MUL_STEPS - 1)) begin
               state_in = papcu_pkg::ST_APPLY;
            end
         end
         papcu_pkg::ST_APPLY: begin
            // Fold the products in and, on an edge pass, seed the root
            if (do_turn_ff) begin
               flags_in = flags_ff | ((acc_turn_ff > 0) ? 2'b01 : 2'b10);
            end
            if (do_edge_ff) begin
               shoelace_in = shoelace_ff + SL_W'(acc_area_ff);
               rad_in      = RW'($unsigned(acc_sq_ff));
               rem_in      = '0;
               root_in     = '0;
               step_in     = '0;
               state_in    = papcu_pkg::ST_ROOT;
            end else begin
               state_in    = papcu_pkg::ST_DISPATCH;
            end
         end
         papcu_pkg::ST_ROOT: begin
            // One root bit per cycle
            rad_in = rad_ff << 2;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               state_in = papcu_pkg::ST_SUM;
            end
         end
         papcu_pkg::ST_SUM: begin
            // Add the edge length, saturating
            length_in = len_sum[RW-1] ? '1 : len_sum[papcu_pkg::PERIM_W-1:0];
            state_in  = papcu_pkg::ST_DISPATCH;
         end
         papcu_pkg::ST_DISPATCH: begin
            // Pick the next pass: idle, closing edge, closing turn or result
            unique case (job_ff)
               papcu_pkg::JOB_VERTEX: begin
                  if (!pend_last_ff) begin
                     state_in = papcu_pkg::ST_IDLE;
                  end else if (!few) begin
                     ld_en    = 1'b1;
                     job_in   = papcu_pkg::JOB_CLOSE_EDGE;
                     state_in = papcu_pkg::ST_MUL;
                  end else begin
                     state_in = papcu_pkg::ST_FINISH;
                  end
               end
               papcu_pkg::JOB_CLOSE_EDGE: begin
                  ld_en    = 1'b1;
                  ld_edge  = 1'b0;
                  ld_nx    = fedge_x_ff;
                  ld_ny    = fedge_y_ff;
                  ld_ox    = close_x;
                  ld_oy    = close_y;
                  job_in   = papcu_pkg::JOB_CLOSE_TURN;
                  state_in = papcu_pkg::ST_MUL;
               end
               papcu_pkg::JOB_CLOSE_TURN: begin
                  state_in = papcu_pkg::ST_FINISH;
               end
               default: begin
                  state_in = papcu_pkg::ST_FINISH;
               end
            endcase
         end
         papcu_pkg::ST_FINISH: begin
            // Register the result once the output is free, then start afresh
            if (!rsp_valid_ff || rsp_tready) begin
               out_load  = 1'b1;
               few_in    = few;
               many_in   = over_ff;
               total_in  = papcu_pkg::TOTAL_W'(count_ff);
               if (few) begin
                  area_in   = '0;
                  perim_in  = '0;
                  convex_in = 1'b0;
               end else begin
                  area_in   = (mag_ext > area_max) ? papcu_pkg::AREA_W'(area_max)
                                                   : papcu_pkg::AREA_W'(mag_ext);
                  perim_in  = length_ff;
                  convex_in = (flags_ff != 2'b11);
               end
               count_in    = '0;
               over_in     = 1'b0;
               flags_in    = '0;
               shoelace_in = '0;
               length_in   = '0;
               state_in    = papcu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = papcu_pkg::ST_IDLE;
         end
      endcase

      // Load a pass into the multiply unit
      if (ld_en) begin
         do_edge_in = ld_edge;
         do_turn_in = ld_turn;
         step_in    = '0;
         m_ax_in    = DW'(ld_ax);
         m_bx_in    = DW'(ld_bx);
         q_by_in    = DW'(ld_by);
         q_ay_in    = DW'(ld_ay);
         m_dx_in    = ld_dx;
         q_dx_in    = ld_dx;
         m_dy_in    = ld_dy;
         q_dy_in    = ld_dy;
         m_nx_in    = ld_nx;
         q_ny_in    = ld_ny;
         m_ox_in    = ld_ox;
         q_oy_in    = ld_oy;
      end

      // Output valid: set on load, drop on transfer
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= papcu_pkg::ST_IDLE;
         job_ff       <= papcu_pkg::JOB_VERTEX;
         pend_last_ff <= 1'b0;
         count_ff     <= '0;
         over_ff      <= 1'b0;
         flags_ff     <= '0;
         step_ff      <= '0;
         do_edge_ff   <= 1'b0;
         do_turn_ff   <= 1'b0;
         shoelace_ff  <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         pend_last_ff <= pend_last_in;
         count_ff     <= count_in;
         over_ff      <= over_in;
         flags_ff     <= flags_in;
         step_ff      <= step_in;
         do_edge_ff   <= do_edge_in;
         do_turn_ff   <= do_turn_in;
         shoelace_ff  <= shoelace_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      first_x_ff  <= first_x_in;
      first_y_ff  <= first_y_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      fedge_x_ff  <= fedge_x_in;
      fedge_y_ff  <= fedge_y_in;
      pedge_x_ff  <= pedge_x_in;
      pedge_y_ff  <= pedge_y_in;
      m_ax_ff     <= m_ax_in;
      m_bx_ff     <= m_bx_in;
      m_dx_ff     <= m_dx_in;
      m_dy_ff     <= m_dy_in;
      m_nx_ff     <= m_nx_in;
      m_ox_ff     <= m_ox_in;
      q_by_ff     <= q_by_in;
      q_ay_ff     <= q_ay_in;
      q_dx_ff     <= q_dx_in;
      q_dy_ff     <= q_dy_in;
      q_oy_ff     <= q_oy_in;
      q_ny_ff     <= q_ny_in;
      acc_area_ff <= acc_area_in;
      acc_sq_ff   <= acc_sq_in;
      acc_turn_ff <= acc_turn_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      area_ff     <= area_in;
      perim_ff    <= perim_in;
      convex_ff   <= convex_in;
      total_ff    <= total_in;
      few_ff      <= few_in;
      many_ff     <= many_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{papcu_pkg::RSP_PAD_W{1'b0}}, many_ff, few_ff, total_ff,
                        convex_ff, perim_ff, area_ff};

endmodule

/* hdl/papcu_checker.sv */
// Port-level checker for the polygon measure unit, bound to its top level.
// Depends on papcu_pkg (field positions) and the assertion macro header.
`include "polygon_area_perimeter_convexity_unit_macros.svh"

module papcu_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [papcu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);

   logic                          few;
   logic                          many;
   logic                          convex;
   logic [papcu_pkg::TOTAL_W-1:0] total;
   logic [papcu_pkg::AREA_W-1:0]  area;
   logic [papcu_pkg::PERIM_W-1:0] perim;
   logic                          req_seen;

   // Unpack the result fields
   assign few      = rsp_tdata[papcu_pkg::FEW_BIT];
   assign many     = rsp_tdata[papcu_pkg::MANY_BIT];
   assign convex   = rsp_tdata[papcu_pkg::CONVEX_BIT];
   assign total    = rsp_tdata[papcu_pkg::TOTAL_LSB +: papcu_pkg::TOTAL_W];
   assign area     = rsp_tdata[papcu_pkg::AREA_W-1:0];
   assign perim    = rsp_tdata[papcu_pkg::PERIM_LSB +: papcu_pkg::PERIM_W];
   assign req_seen = req_tvalid && req_tready;

   // A stalled result holds still
   `PAPCU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // A short ring reports zero measures and a count below three
   `PAPCU_ASSERT_NOW(a_few_zero, clock, reset, rsp_tvalid && few,
      area == '0 && perim == '0 && !convex && total < 3, "short ring result not zero")

   // Overflow means the ring reached capacity, never a short ring
   `PAPCU_ASSERT_NOW(a_many_not_few, clock, reset, rsp_tvalid && many,
      !few, "overflow flagged on a short ring")

   // Reset empties the output
   `PAPCU_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset,
      !rsp_tvalid && !($past(req_seen) && $past(reset)) || !rsp_tvalid,
      "result valid after reset")

endmodule

bind polygon_area_perimeter_convexity_unit papcu_checker u_papcu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

/* tb/tb_top.sv */
// Self-checking bench for the polygon measure unit: vertex rings in, area/perimeter/convexity out.
// Depends on papcu_pkg and polygon_area_perimeter_convexity_unit; a scoreboard class predicts
// each ring result while plain tasks drive the req_ stream and a free-running pattern stalls rsp_.
module tb_top;
   import papcu_pkg::*;

   localparam int CAPACITY      = DEF_MAX_VERTICES;
   localparam int FRAC_BITS     = DEF_FRACTION_BITS;
   localparam int RANDOM_ITEMS  = 100;
   localparam int QUIET_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 300;
   localparam int REPORT_LINES  = 100;

   localparam longint unsigned AREA_SAT  = (64'd1 << AREA_W) - 1;
   localparam longint unsigned PERIM_SAT = (64'd1 << PERIM_W) - 1;

   // x in the low half, matching the req_tdata layout
   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_t;

   typedef struct packed {
      logic [AREA_W-1:0]  area2;
      logic [PERIM_W-1:0] perim;
      logic               convex;
      logic [TOTAL_W-1:0] total;
      logic               few;
      logic               many;
   } measure_t;

   typedef enum {
      RX_ALWAYS,
      RX_RANDOM,
      RX_SPARSE,
      RX_BLOCKED
   } stall_mode_t;

   typedef enum {
      SHAPE_SCATTER,
      SHAPE_CLUSTER,
      SHAPE_BOX,
      SHAPE_HEX,
      SHAPE_STUCK,
      SHAPE_EXTREME
   } shape_t;

   // Running measure of the open ring and the queue of ring results still owed
   class polygon_scoreboard;
      longint          first_x, first_y, prev_x, prev_y;
      longint          first_dx, first_dy, prev_dx, prev_dy;
      longint          twice_area;
      longint unsigned perim_sum;
      bit              saw_left, saw_right, dropped;
      int unsigned     taken;
      measure_t        owed_q[$];
      int              error_count;

      function new();
         error_count = 0;
         restart();
      endfunction

      function void restart();
         first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
         first_dx = 0; first_dy = 0; prev_dx = 0; prev_dy = 0;
         twice_area = 0;
         perim_sum = 0;
         saw_left = 0; saw_right = 0; dropped = 0;
         taken = 0;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         error_count++;
         if (error_count <= REPORT_LINES)
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      endtask

      // floor(sqrt(sq) * 2^FRAC_BITS) as an integer root of the scaled square
      function longint unsigned edge_length_fx(longint unsigned sq);
         longint unsigned n, root, probe;
         n = sq << (2 * FRAC_BITS);
         root = 0;
         probe = 64'd1 << 62;
         while (probe > n) probe >>= 2;
         while (probe != 0) begin
            if (n >= root + probe) begin
               n -= root + probe;
               root = (root >> 1) + probe;
            end else begin
               root >>= 1;
            end
            probe >>= 2;
         end
         return root;
      endfunction

      function void add_edge(longint ax, longint ay, longint bx, longint by);
         longint dx, dy;
         dx = bx - ax;
         dy = by - ay;
         twice_area += ax * by - bx * ay;
         perim_sum += edge_length_fx(longint'(dx * dx + dy * dy));
      endfunction

      // collinear and degenerate turns fall in the non-positive class
      function void add_turn(longint nx, longint ny, longint ox, longint oy);
         if (nx * oy - ox * ny > 0) saw_left = 1;
         else saw_right = 1;
      endfunction

      function void note_vertex(logic signed [COORD_W-1:0] vx, logic signed [COORD_W-1:0] vy,
                                logic closes);
         longint          x, y, dx, dy, cx, cy;
         longint unsigned mag;
         measure_t        m;
         x = vx;
         y = vy;
         // drop vertices past capacity, the closing one too
         if (taken >= CAPACITY) begin
            dropped = 1;
         end else begin
            if (taken == 0) begin
               first_x = x;
               first_y = y;
            end else begin
               dx = x - prev_x;
               dy = y - prev_y;
               add_edge(prev_x, prev_y, x, y);
               if (taken == 1) begin
                  first_dx = dx;
                  first_dy = dy;
               end else begin
                  add_turn(dx, dy, prev_dx, prev_dy);
               end
               prev_dx = dx;
               prev_dy = dy;
            end
            prev_x = x;
            prev_y = y;
            taken++;
         end
         if (!closes) return;

         m = '0;
         m.total = TOTAL_W'(taken);
         m.few = (taken < 3);
         m.many = dropped;
         // close the ring back to the first vertex
         if (!m.few) begin
            cx = first_x - prev_x;
            cy = first_y - prev_y;
            add_edge(prev_x, prev_y, first_x, first_y);
            add_turn(cx, cy, prev_dx, prev_dy);
            add_turn(first_dx, first_dy, cx, cy);
            mag = (twice_area < 0) ? longint'(-twice_area) : longint'(twice_area);
            m.area2 = (mag > AREA_SAT) ? AREA_SAT[AREA_W-1:0] : mag[AREA_W-1:0];
            m.perim = (perim_sum > PERIM_SAT) ? PERIM_SAT[PERIM_W-1:0] : perim_sum[PERIM_W-1:0];
            m.convex = !(saw_left && saw_right);
         end
         owed_q = {owed_q, m};
         restart();
      endfunction

      task check_result(logic [RSP_DATA_W-1:0] d);
         measure_t want;
         if (owed_q.size() == 0) begin
            report("result with no ring pending", d[AREA_W-1:0], 0);
            return;
         end
         want = owed_q.pop_front();
         if (d[AREA_W-1:0] !== want.area2)
            report("double_area", d[AREA_W-1:0], want.area2);
         if (d[PERIM_LSB +: PERIM_W] !== want.perim)
            report("perimeter_fx", d[PERIM_LSB +: PERIM_W], want.perim);
         if (d[CONVEX_BIT] !== want.convex)
            report("is_convex", d[CONVEX_BIT], want.convex);
         if (d[TOTAL_LSB +: TOTAL_W] !== want.total)
            report("vertex_total", d[TOTAL_LSB +: TOTAL_W], want.total);
         if (d[FEW_BIT] !== want.few)
            report("too_few", d[FEW_BIT], want.few);
         if (d[MANY_BIT] !== want.many)
            report("too_many", d[MANY_BIT], want.many);
         if (d[RSP_DATA_W-1 -: RSP_PAD_W] !== '0)
            report("padding", d[RSP_DATA_W-1 -: RSP_PAD_W], 0);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   polygon_scoreboard sb = new();

   point_t      ring[$];
   int          burst_left = 0;
   int          quiet_cycles = 0;
   stall_mode_t rx_mode = RX_ALWAYS;
   int          rx_mode_left = 0;
   int          rx_tick = 0;

   polygon_area_perimeter_convexity_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #5 clock = ~clock;

   // Receiver: switch between stall modes after runs of random length
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode = stall_mode_t'($urandom_range(0, 3));
         rx_mode_left = $urandom_range(20, 300);
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
         RX_ALWAYS:  rsp_tready <= 1'b1;
         RX_RANDOM:  rsp_tready <= ($urandom_range(0, 99) >= 40);
         RX_SPARSE:  rsp_tready <= (rx_tick % 4 == 0);
         default:    rsp_tready <= (rx_tick % 64 >= 48);
      endcase
   end

   // Observe both channels at the edge; feed the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_vertex(req_tdata[COORD_W-1:0], req_tdata[REQ_DATA_W-1 -: COORD_W], req_tlast);
      end
   end

   // Watchdog: give up after a long stretch with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic point_t pt(int x, int y);
      point_t p;
      p.x = COORD_W'(x);
      p.y = COORD_W'(y);
      return p;
   endfunction

   function automatic point_t any_point();
      return pt($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
   endfunction

   // Sender: bursts of back-to-back transfers separated by random gaps
   task automatic send_vertex(point_t p, logic closes);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap = 0;
            5, 6, 7:       gap = $urandom_range(1, 4);
            8:             gap = $urandom_range(5, 30);
            default:       gap = $urandom_range(40, 120);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata <= p;
      req_tlast <= closes;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_ring();
      foreach (ring[i]) send_vertex(ring[i], i == ring.size() - 1);
   endtask

   // Hold the sender until every owed result has been taken
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic build_random_ring();
      shape_t shape;
      int     n, cx, cy, span, s, x0, x1, y0, y1, dx, dy;
      int     hex_dx[6] = '{2, 1, -1, -2, -1, 1};
      int     hex_dy[6] = '{0, 2, 2, 0, -2, -2};
      int     corner[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      ring.delete();
      case ($urandom_range(0, 19))
         0:       n = $urandom_range(1, 2);
         1:       n = $urandom_range(11, 40);
         default: n = $urandom_range(3, 10);
      endcase
      shape = shape_t'($urandom_range(0, 5));
      case (shape)
         SHAPE_SCATTER: begin
            repeat (n) ring = {ring, any_point()};
         end
         SHAPE_CLUSTER: begin
            cx = $urandom_range(0, 60000) - 30000;
            cy = $urandom_range(0, 60000) - 30000;
            span = 1 << $urandom_range(0, 11);
            repeat (n)
               ring = {ring, pt(cx + $urandom_range(0, 2 * span) - span,
                                cy + $urandom_range(0, 2 * span) - span)};
         end
         SHAPE_BOX: begin
            x0 = $urandom_range(0, 65535) - 32768;
            x1 = $urandom_range(x0 + 32768, 65535) - 32768;
            y0 = $urandom_range(0, 65535) - 32768;
            y1 = $urandom_range(y0 + 32768, 65535) - 32768;
            ring = {pt(x0, y0), pt(x1, y0), pt(x1, y1), pt(x0, y1)};
         end
         SHAPE_HEX: begin
            s = $urandom_range(1, 8000);
            cx = $urandom_range(0, 16000) - 8000;
            cy = $urandom_range(0, 16000) - 8000;
            for (int k = 0; k < 6; k++)
               ring = {ring, pt(cx + s * hex_dx[k], cy + s * hex_dy[k])};
         end
         SHAPE_STUCK: begin
            // repeated points or points along one line
            cx = $urandom_range(0, 2000) - 1000;
            cy = $urandom_range(0, 2000) - 1000;
            dx = $urandom_range(0, 1) ? 0 : $urandom_range(0, 20) - 10;
            dy = $urandom_range(0, 20) - 10;
            for (int k = 0; k < n; k++) ring = {ring, pt(cx + k * dx, cy + k * dy)};
         end
         default: begin
            repeat (n)
               ring = {ring, pt(corner[$urandom_range(0, 6)], corner[$urandom_range(0, 6)])};
         end
      endcase
      if ($urandom_range(0, 1)) ring.reverse();
   endtask

   initial begin
      int items_done;
      int cap_stage;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: too few vertices
      ring = {pt(0, 0)};
      send_ring();
      ring = {pt(-32768, -32768), pt(32767, 32767)};
      send_ring();
      // full-range square, counterclockwise
      ring = {pt(-32768, -32768), pt(32767, -32768), pt(32767, 32767), pt(-32768, 32767)};
      send_ring();
      // full-range triangle, clockwise
      ring = {pt(32767, 32767), pt(32767, -32768), pt(-32768, -32768)};
      send_ring();
      // concave quadrilateral
      ring = {pt(0, 0), pt(10, 0), pt(3, 3), pt(0, 10)};
      send_ring();
      // all vertices on one spot, then all on one line
      ring = {pt(5, 5), pt(5, 5), pt(5, 5)};
      send_ring();
      ring = {pt(0, 0), pt(100, 0), pt(200, 0)};
      send_ring();
      drain_results();

      // Random rings, with one ring past capacity along the way
      items_done = 0;
      cap_stage = 0;
      while (items_done < RANDOM_ITEMS) begin
         if (cap_stage < 1 && items_done >= RANDOM_ITEMS / 2) begin
            drain_results();
            ring.delete();
            repeat (CAPACITY + 2) ring = {ring, any_point()};
            send_ring();
            cap_stage++;
         end
         build_random_ring();
         send_ring();
         items_done += ring.size();
      end

      // Wait out the last results, then settle
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* polygon_area_perimeter_convexity_unit.f */
+incdir+hdl
hdl/papcu_pkg.sv
hdl/polygon_area_perimeter_convexity_unit.sv
hdl/papcu_checker.sv
tb/tb_top.sv
